// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/clr_pkg.sv -----
`timescale 1ns / 1ps

package clr_pkg;

    localparam int CLIP_BITS      = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CLIP_BITS-1:0] CLIP_RESET = 11'd2047;

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CLIP_WIDTH  = 1'b0,
        CFG_CLIP_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

// ----- rtl/core/clipped_line_rasterizer.sv -----
`timescale 1ns / 1ps
// Bresenham line stepper with a clip window.
// Input stream (s_*): s_tuser is the command. A start beat (CMD_START) loads
// the end points and colour from s_tdata and returns one beat with no pixel.
// Each step beat (CMD_STEP) returns either one pixel (m_tuser = 1) and
// advances the line, or an end beat (m_tuser = 0, m_tlast = 1) once the
// current point reaches the end point or leaves the clip window. A step with
// no line loaded also returns an end beat.
// Output stream (m_*): exactly one result beat per input beat, in order.
// The output is registered: the beat accepted at an edge is on m_* after it.
// Throughput is one beat per cycle unless the receiver stalls; the step logic
// is one small add and compare between the line state registers and the output
// register. When the receiver stalls, the output register holds its beat and
// s_tready drops until that beat is taken; nothing is lost or repeated.
// Configuration (cfg_*): cfg_index 0 writes clip_width, 1 writes clip_height,
// both take effect on the next step; write only while the block is idle.
// Reset (rst_n low) clears the output valid flag, drops the loaded line and
// sets both clip limits to 2047.

`include "assert_macros.svh"

module clipped_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // config write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [clr_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [clr_pkg::CLIP_BITS-1:0]             cfg_data,
    // command stream
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // start_x, start_y, end_x, end_y, color, zero pad
    input  logic [((4*COORD_BITS+32+7)/8)*8-1:0]      s_tdata,
    // cmd
    input  logic                                      s_tuser,
    // pixel stream
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+32+7)/8)*8-1:0]      m_tdata,
    // pixel_valid
    output logic                                      m_tuser,
    // line_done
    output logic                                      m_tlast
);

    import clr_pkg::*;

    localparam int CB        = COORD_BITS;
    localparam int EB        = COORD_BITS + 2;
    localparam int M_TDATA_W = ((2*COORD_BITS+32+7)/8)*8;
    localparam int CMPW      = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

    // clip limits
    logic [CLIP_BITS-1:0] clip_width_reg, clip_height_reg;

    // line state
    logic signed [CB-1:0] cur_x_reg, cur_y_reg, target_x_reg, target_y_reg;
    logic signed [CB-1:0] cur_x_next, cur_y_next, target_x_next, target_y_next;
    logic [CB-1:0]        delta_x_reg, delta_y_reg, delta_x_next, delta_y_next;
    logic                 dir_x_neg_reg, dir_y_neg_reg, dir_x_neg_next, dir_y_neg_next;
    logic signed [EB-1:0] error_reg, error_next;
    logic [31:0]          line_color_reg, line_color_next;
    logic                 active_reg, active_next;

    // output register
    logic                 m_tvalid_reg;
    logic signed [CB-1:0] pix_x_reg, pix_y_reg, pix_x_next, pix_y_next;
    logic [31:0]          pix_color_reg, pix_color_next;
    logic                 pix_valid_reg, pix_valid_next;
    logic                 done_reg, done_next;

    logic                 accept;
    logic signed [CB-1:0] sx, sy, fx, fy;
    logic [31:0]          in_color;
    logic signed [CB:0]   diff_x, diff_y;
    logic [CB-1:0]        abs_x, abs_y;
    logic signed [EB:0]   e2, dx_ext, dy_ext, err_sum;
    logic                 step_x, step_y, at_end, outside;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign sx       = s_tdata[CB-1:0];
    assign sy       = s_tdata[2*CB-1:CB];
    assign fx       = s_tdata[3*CB-1:2*CB];
    assign fy       = s_tdata[4*CB-1:3*CB];
    assign in_color = s_tdata[4*CB+31:4*CB];

    // load-time deltas
    assign diff_x = {fx[CB-1], fx} - {sx[CB-1], sx};
    assign diff_y = {fy[CB-1], fy} - {sy[CB-1], sy};
    assign abs_x  = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
    assign abs_y  = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];

    // step decisions, e2 = 2 * error kept one bit wider so it never wraps
    assign e2      = {error_reg, 1'b0};
    assign dx_ext  = $signed({3'b000, delta_x_reg});
    assign dy_ext  = $signed({3'b000, delta_y_reg});
    assign step_x  = e2 > -dy_ext;
    assign step_y  = e2 < dx_ext;
    assign err_sum = {error_reg[EB-1], error_reg}
                   - (step_x ? dy_ext : '0)
                   + (step_y ? dx_ext : '0);

    assign at_end  = (cur_x_reg == target_x_reg) && (cur_y_reg == target_y_reg);
    assign outside = cur_x_reg[CB-1] || cur_y_reg[CB-1]
                  || (CMPW'($unsigned(cur_x_reg)) >= CMPW'(clip_width_reg))
                  || (CMPW'($unsigned(cur_y_reg)) >= CMPW'(clip_height_reg));

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        dir_x_neg_next  = dir_x_neg_reg;
        dir_y_neg_next  = dir_y_neg_reg;
        error_next      = error_reg;
        line_color_next = line_color_reg;
        active_next     = active_reg;
        pix_x_next      = '0;
        pix_y_next      = '0;
        pix_color_next  = '0;
        pix_valid_next  = 1'b0;
        done_next       = 1'b0;
        case (cmd_t'(s_tuser))
            CMD_START:
            begin
                cur_x_next      = sx;
                cur_y_next      = sy;
                target_x_next   = fx;
                target_y_next   = fy;
                delta_x_next    = abs_x;
                delta_y_next    = abs_y;
                dir_x_neg_next  = !(sx < fx);
                dir_y_neg_next  = !(sy < fy);
                error_next      = $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});
                line_color_next = in_color;
                active_next     = 1'b1;
            end
            CMD_STEP:
            begin
                if (!active_reg)
                begin
                    done_next = 1'b1;
                end
                else if (at_end || outside)
                begin
                    done_next   = 1'b1;
                    active_next = 1'b0;
                end
                else
                begin
                    pix_x_next     = cur_x_reg;
                    pix_y_next     = cur_y_reg;
                    pix_color_next = line_color_reg;
                    pix_valid_next = 1'b1;
                    if (step_x)
                    begin
                        cur_x_next = cur_x_reg + (dir_x_neg_reg ? {CB{1'b1}} : CB'(1));
                    end
                    if (step_y)
                    begin
                        cur_y_next = cur_y_reg + (dir_y_neg_reg ? {CB{1'b1}} : CB'(1));
                    end
                    error_next = err_sum[EB-1:0];
                end
            end
            default:
            begin
                done_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_width_reg  <= CLIP_RESET;
            clip_height_reg <= CLIP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_data;
                CFG_CLIP_HEIGHT: clip_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            active_reg   <= active_next;
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload and line state, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            dir_x_neg_reg  <= dir_x_neg_next;
            dir_y_neg_reg  <= dir_y_neg_next;
            error_reg      <= error_next;
            line_color_reg <= line_color_next;
            pix_x_reg      <= pix_x_next;
            pix_y_reg      <= pix_y_next;
            pix_color_reg  <= pix_color_next;
            pix_valid_reg  <= pix_valid_next;
            done_reg       <= done_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({pix_color_reg, pix_y_reg, pix_x_reg});
    assign m_tuser  = pix_valid_reg;
    assign m_tlast  = done_reg;

    `ASSERT_IMP(a_pixel_not_done, m_tvalid && m_tuser, !m_tlast)
    `ASSERT_IMP(a_no_pixel_zero_data, m_tvalid && !m_tuser, m_tdata == '0)
    `ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `ASSERT_NXT(a_start_loads_line, accept && (s_tuser == CMD_START),
                active_reg && m_tvalid && !m_tuser && !m_tlast)
    `ASSERT_NXT(a_idle_step_ends, accept && (s_tuser == CMD_STEP) && !active_reg,
                m_tlast && !m_tuser && !active_reg)

endmodule
